### rtl/pjs_pkg.sv
// Shared types, constants and codes of the priority job scheduler.
`timescale 1ns / 1ps

package pjs_pkg;

  // Default sizing of the ready queue and of the time arithmetic.
  localparam int PJS_QUEUE_DEPTH = 32;
  localparam int PJS_TIME_BITS   = 32;

  // Width of the time fields on the result channel.
  localparam int PJS_OUT_TIME_W = 32;

  // Result status codes.
  localparam logic STATUS_DONE   = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  // Fixed-width part of one job as kept in the job memory.
  typedef struct packed {
    logic [7:0]  prio;
    logic [7:0]  id;
    logic [15:0] burst;
  } pjs_job_t;

  // Strobes from the controller to the job and link memories.
  typedef struct packed {
    logic rd_en;
    logic data_we;
    logic link_we;
  } pjs_mem_ctl_t;

  // One result record, handed from the controller to the output register.
  typedef struct packed {
    logic                      status;
    logic [7:0]                id;
    logic [PJS_OUT_TIME_W-1:0] arrival;
    logic [15:0]               burst;
    logic [7:0]                prio;
    logic [PJS_OUT_TIME_W-1:0] waiting;
    logic [PJS_OUT_TIME_W-1:0] completion;
    logic [PJS_OUT_TIME_W-1:0] turnaround;
    logic                      last;
  } pjs_result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_POP_CALC,
    ST_POP_OUT,
    ST_REJECT,
    ST_INS,
    ST_WALK,
    ST_LINK
  } pjs_state_t;

endpackage

### rtl/pjs_store.sv
// Job memory and link memory of the ready queue, one shared registered read port.
`timescale 1ns / 1ps

module pjs_store #(
  parameter int DEPTH     = 32,
  parameter int TIME_BITS = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  pjs_pkg::pjs_mem_ctl_t                  ctl,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] data_waddr,
  input  pjs_pkg::pjs_job_t                      data_wjob,
  input  logic [TIME_BITS-1:0]                   data_warr,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] link_waddr,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] link_wdata,
  output pjs_pkg::pjs_job_t                      rd_job,
  output logic [TIME_BITS-1:0]                   rd_arr,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_link
);
  import pjs_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int JOB_W = $bits(pjs_job_t);

  logic [JOB_W+TIME_BITS-1:0] data_mem [DEPTH];
  logic [IDX_W-1:0]           link_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.data_we) begin
      data_mem[data_waddr] <= {data_wjob, data_warr};
    end
    if (ctl.rd_en) begin
      {rd_job, rd_arr} <= data_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (ctl.rd_en) begin
      rd_link <= link_mem[rd_addr];
    end
  end

  // The controller never reads and rewrites the same link entry in one cycle.
  a_link_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.rd_en && ctl.link_we) |-> (rd_addr != link_waddr))
    else $error("link memory read and write hit the same entry");

endmodule

### rtl/pjs_ctrl.sv
// Scheduler controller: linked ready queue, free list, time keeping and dispatch.
`timescale 1ns / 1ps

module pjs_ctrl #(
  parameter int DEPTH     = 32,
  parameter int TIME_BITS = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  pjs_pkg::pjs_job_t                      in_job,
  input  logic [31:0]                            in_arrival,
  input  logic                                   in_last,
  input  logic                                   out_free,
  output logic                                   res_load,
  output pjs_pkg::pjs_result_t                   res,
  output pjs_pkg::pjs_mem_ctl_t                  mem_ctl,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] data_waddr,
  output pjs_pkg::pjs_job_t                      data_wjob,
  output logic [TIME_BITS-1:0]                   data_warr,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] link_waddr,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] link_wdata,
  input  pjs_pkg::pjs_job_t                      rd_job,
  input  logic [TIME_BITS-1:0]                   rd_arr,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_link
);
  import pjs_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [TIME_BITS-1:0] TMAX = '1;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  pjs_state_t           state_r, state_nxt;
  logic                 drain_r, drain_nxt;
  logic [TIME_BITS-1:0] cur_time_r, cur_time_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     fresh_r, fresh_nxt;
  logic [IDX_W-1:0]     free_head_r, free_head_nxt;
  logic [IDX_W-1:0]     head_r, head_nxt;
  logic [IDX_W-1:0]     tail_r, tail_nxt;
  logic [7:0]           tail_prio_r, tail_prio_nxt;
  logic [IDX_W-1:0]     slot_r, slot_nxt;
  logic                 from_free_r, from_free_nxt;
  logic [IDX_W-1:0]     prev_r, prev_nxt;
  logic [IDX_W-1:0]     cur_r, cur_nxt;
  logic                 have_prev_r, have_prev_nxt;

  pjs_job_t             job_r, job_nxt;
  logic [TIME_BITS-1:0] job_arr_r, job_arr_nxt;
  logic                 job_last_r, job_last_nxt;
  pjs_job_t             pop_job_r, pop_job_nxt;
  logic [TIME_BITS-1:0] pop_arr_r, pop_arr_nxt;
  logic [TIME_BITS-1:0] pop_wt_r, pop_wt_nxt;

  logic [63:0]          arr_wide;
  logic [TIME_BITS-1:0] arr_clamp;
  logic [TIME_BITS:0]   ct_sum;
  logic [TIME_BITS-1:0] ct_calc;
  logic [TIME_BITS-1:0] wt_calc;
  logic [TIME_BITS-1:0] tat_calc;
  logic                 time_lt;
  logic                 count_zero;
  logic                 queue_full;
  logic                 use_fresh;

  // Arrivals beyond the time range are clamped to the largest time.
  assign arr_wide  = 64'(in_arrival);
  assign arr_clamp = (arr_wide > 64'(TMAX)) ? TMAX : TIME_BITS'(arr_wide);

  // Completion time saturates; waiting and turnaround floor at zero.
  assign ct_sum   = {1'b0, cur_time_r} + (TIME_BITS + 1)'(rd_job.burst);
  assign ct_calc  = ct_sum[TIME_BITS] ? TMAX : ct_sum[TIME_BITS-1:0];
  assign wt_calc  = (cur_time_r >= rd_arr) ? (cur_time_r - rd_arr) : '0;
  assign tat_calc = (cur_time_r >= pop_arr_r) ? (cur_time_r - pop_arr_r) : '0;

  assign time_lt    = cur_time_r < job_arr_r;
  assign count_zero = count_r == '0;
  assign queue_full = count_r == CNT_FULL;
  assign use_fresh  = fresh_r < CNT_FULL;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      drain_r     <= 1'b0;
      cur_time_r  <= '0;
      count_r     <= '0;
      fresh_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      drain_r     <= drain_nxt;
      cur_time_r  <= cur_time_nxt;
      count_r     <= count_nxt;
      fresh_r     <= fresh_nxt;
    end
  end

  always_ff @(posedge clk) begin
    free_head_r <= free_head_nxt;
    head_r      <= head_nxt;
    tail_r      <= tail_nxt;
    tail_prio_r <= tail_prio_nxt;
    slot_r      <= slot_nxt;
    from_free_r <= from_free_nxt;
    prev_r      <= prev_nxt;
    cur_r       <= cur_nxt;
    have_prev_r <= have_prev_nxt;
    job_r       <= job_nxt;
    job_arr_r   <= job_arr_nxt;
    job_last_r  <= job_last_nxt;
    pop_job_r   <= pop_job_nxt;
    pop_arr_r   <= pop_arr_nxt;
    pop_wt_r    <= pop_wt_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    drain_nxt     = drain_r;
    cur_time_nxt  = cur_time_r;
    count_nxt     = count_r;
    fresh_nxt     = fresh_r;
    free_head_nxt = free_head_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    tail_prio_nxt = tail_prio_r;
    slot_nxt      = slot_r;
    from_free_nxt = from_free_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    have_prev_nxt = have_prev_r;
    job_nxt       = job_r;
    job_arr_nxt   = job_arr_r;
    job_last_nxt  = job_last_r;
    pop_job_nxt   = pop_job_r;
    pop_arr_nxt   = pop_arr_r;
    pop_wt_nxt    = pop_wt_r;

    in_ready   = 1'b0;
    res_load   = 1'b0;
    res        = '0;
    mem_ctl    = '0;
    rd_addr    = head_r;
    data_waddr = slot_r;
    data_wjob  = job_r;
    data_warr  = job_arr_r;
    link_waddr = slot_r;
    link_wdata = cur_r;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          job_nxt      = in_job;
          job_arr_nxt  = arr_clamp;
          job_last_nxt = in_last;
          drain_nxt    = 1'b0;
          state_nxt    = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        if (!count_zero && (drain_r || time_lt)) begin
          // Dispatch the head of the queue.
          mem_ctl.rd_en = 1'b1;
          rd_addr       = head_r;
          state_nxt     = ST_POP_CALC;
        end else if (drain_r) begin
          state_nxt = ST_IDLE;
        end else begin
          if (count_zero && time_lt) begin
            cur_time_nxt = job_arr_r;
          end
          if (queue_full) begin
            state_nxt = ST_REJECT;
          end else begin
            // Never-used slots go first, then recycled ones from the free list.
            slot_nxt      = use_fresh ? fresh_r[IDX_W-1:0] : free_head_r;
            from_free_nxt = !use_fresh;
            if (use_fresh) begin
              fresh_nxt = fresh_r + 1'b1;
            end else begin
              mem_ctl.rd_en = 1'b1;
              rd_addr       = free_head_r;
            end
            mem_ctl.data_we = 1'b1;
            data_waddr      = slot_nxt;
            count_nxt       = count_r + 1'b1;
            state_nxt       = ST_INS;
          end
        end
      end

      ST_POP_CALC: begin
        pop_job_nxt     = rd_job;
        pop_arr_nxt     = rd_arr;
        pop_wt_nxt      = wt_calc;
        cur_time_nxt    = ct_calc;
        head_nxt        = rd_link;
        // The departing slot goes on top of the free list.
        mem_ctl.link_we = 1'b1;
        link_waddr      = head_r;
        link_wdata      = free_head_r;
        free_head_nxt   = head_r;
        count_nxt       = count_r - 1'b1;
        state_nxt       = ST_POP_OUT;
      end

      ST_POP_OUT: begin
        if (out_free) begin
          res_load       = 1'b1;
          res.status     = STATUS_DONE;
          res.id         = pop_job_r.id;
          res.arrival    = PJS_OUT_TIME_W'(pop_arr_r);
          res.burst      = pop_job_r.burst;
          res.prio       = pop_job_r.prio;
          res.waiting    = PJS_OUT_TIME_W'(pop_wt_r);
          res.completion = PJS_OUT_TIME_W'(cur_time_r);
          res.turnaround = PJS_OUT_TIME_W'(tat_calc);
          // Before the insert, more output follows only if another dispatch
          // is due or the job is the last one and the drain comes after it.
          res.last       = drain_r ? count_zero
                                   : (!job_last_r && (count_zero || !time_lt));
          state_nxt      = ST_DECIDE;
        end
      end

      ST_REJECT: begin
        if (out_free) begin
          res_load    = 1'b1;
          res.status  = STATUS_REJECT;
          res.id      = job_r.id;
          res.arrival = PJS_OUT_TIME_W'(job_arr_r);
          res.burst   = job_r.burst;
          res.prio    = job_r.prio;
          res.last    = !job_last_r;
          if (job_last_r) begin
            drain_nxt = 1'b1;
            state_nxt = ST_DECIDE;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_INS: begin
        if (from_free_r) begin
          free_head_nxt = rd_link;
        end
        if (count_r == CNT_ONE) begin
          head_nxt      = slot_r;
          tail_nxt      = slot_r;
          tail_prio_nxt = job_r.prio;
          drain_nxt     = job_last_r;
          state_nxt     = job_last_r ? ST_DECIDE : ST_IDLE;
        end else if (job_r.prio >= tail_prio_r) begin
          // Append behind the tail; equal priorities keep arrival order.
          mem_ctl.link_we = 1'b1;
          link_waddr      = tail_r;
          link_wdata      = slot_r;
          tail_nxt        = slot_r;
          tail_prio_nxt   = job_r.prio;
          drain_nxt       = job_last_r;
          state_nxt       = job_last_r ? ST_DECIDE : ST_IDLE;
        end else begin
          mem_ctl.rd_en = 1'b1;
          rd_addr       = head_r;
          cur_nxt       = head_r;
          have_prev_nxt = 1'b0;
          state_nxt     = ST_WALK;
        end
      end

      ST_WALK: begin
        if (rd_job.prio <= job_r.prio) begin
          have_prev_nxt = 1'b1;
          prev_nxt      = cur_r;
          cur_nxt       = rd_link;
          mem_ctl.rd_en = 1'b1;
          rd_addr       = rd_link;
        end else begin
          mem_ctl.link_we = 1'b1;
          link_waddr      = slot_r;
          link_wdata      = cur_r;
          state_nxt       = ST_LINK;
        end
      end

      ST_LINK: begin
        if (have_prev_r) begin
          mem_ctl.link_we = 1'b1;
          link_waddr      = prev_r;
          link_wdata      = slot_r;
        end else begin
          head_nxt = slot_r;
        end
        drain_nxt = job_last_r;
        state_nxt = job_last_r ? ST_DECIDE : ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("queue count exceeds the queue depth");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> out_free)
    else $error("result loaded into a full output register");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POP_CALC) |=> (CNT_W'(count_r + 1'b1) == $past(count_r)))
    else $error("dispatch did not shrink the queue by one");

  a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (count_r > CNT_ONE))
    else $error("ordered insert walk on a queue without other entries");

endmodule

### rtl/priority_job_scheduler.sv
// Top level of the non-preemptive priority job scheduler.
`timescale 1ns / 1ps

// Each transfer on the in_ channel is one job, in arrival order. Before the
// job is queued, queued jobs are dispatched (lowest priority number first,
// equal priorities in arrival order) while the current time is before the
// job's arrival; an empty queue lets the time jump to the arrival. A job
// with in_tlast set drains the whole queue afterwards. Each dispatch gives
// one transfer on the out_ channel with waiting, completion and turnaround
// times; a job that finds the queue full gives one record with status
// reject. out_tlast marks the final record caused by an input job.
// Steps: accept, decide, then insert at the tail or into an empty queue,
// or, for an ordered insert further up, a walk that reads the queued
// entries one by one from the head and a final link write. Each dispatch
// reads the memories, updates the time and loads the output register; the
// job and link memories share one read port. One job is handled at a time.
// Reset (synchronous, rst_n low) empties the queue and zeroes the time; the
// memories need no clearing. A stalled receiver holds the output register;
// the block keeps accepting and queuing jobs until it needs that register.
module priority_job_scheduler #(
  parameter int QUEUE_DEPTH = pjs_pkg::PJS_QUEUE_DEPTH,
  parameter int TIME_BITS   = pjs_pkg::PJS_TIME_BITS
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // process_id[7:0], arrival_time[39:8], burst_time[55:40], priority_req[63:56]
  input  logic [63:0]  in_tdata,
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // job_id[7:0], job_arrival[39:8], job_burst[55:40], job_priority[63:56],
  // waiting_time[95:64], completion_time[127:96], turnaround_time[159:128]
  output logic [159:0] out_tdata,
  // status[0]
  output logic [0:0]   out_tuser,
  output logic         out_tlast
);
  import pjs_pkg::*;

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  pjs_job_t             in_job;
  logic                 out_free;
  logic                 res_load;
  pjs_result_t          res;
  pjs_mem_ctl_t         mem_ctl;
  logic [IDX_W-1:0]     rd_addr;
  logic [IDX_W-1:0]     data_waddr;
  pjs_job_t             data_wjob;
  logic [TIME_BITS-1:0] data_warr;
  logic [IDX_W-1:0]     link_waddr;
  logic [IDX_W-1:0]     link_wdata;
  pjs_job_t             rd_job;
  logic [TIME_BITS-1:0] rd_arr;
  logic [IDX_W-1:0]     rd_link;

  logic                 out_valid_r;
  pjs_result_t          out_res_r;

  assign in_job.id    = in_tdata[7:0];
  assign in_job.burst = in_tdata[55:40];
  assign in_job.prio  = in_tdata[63:56];

  pjs_ctrl #(
    .DEPTH     (QUEUE_DEPTH),
    .TIME_BITS (TIME_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_job     (in_job),
    .in_arrival (in_tdata[39:8]),
    .in_last    (in_tlast),
    .out_free   (out_free),
    .res_load   (res_load),
    .res        (res),
    .mem_ctl    (mem_ctl),
    .rd_addr    (rd_addr),
    .data_waddr (data_waddr),
    .data_wjob  (data_wjob),
    .data_warr  (data_warr),
    .link_waddr (link_waddr),
    .link_wdata (link_wdata),
    .rd_job     (rd_job),
    .rd_arr     (rd_arr),
    .rd_link    (rd_link)
  );

  pjs_store #(
    .DEPTH     (QUEUE_DEPTH),
    .TIME_BITS (TIME_BITS)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (mem_ctl),
    .rd_addr    (rd_addr),
    .data_waddr (data_waddr),
    .data_wjob  (data_wjob),
    .data_warr  (data_warr),
    .link_waddr (link_waddr),
    .link_wdata (link_wdata),
    .rd_job     (rd_job),
    .rd_arr     (rd_arr),
    .rd_link    (rd_link)
  );

  // The output register can take a new record when empty or when the
  // record it holds is leaving in this cycle.
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.turnaround, out_res_r.completion, out_res_r.waiting,
                       out_res_r.prio, out_res_r.burst, out_res_r.arrival, out_res_r.id};
  assign out_tuser  = out_res_r.status;
  assign out_tlast  = out_res_r.last;

endmodule
